### rtl/core/apogee_descent_detector_core_defines.svh
// ----------------------------------------------------------------------------
// Apogee descent detector assertion macros
// Concurrent assertion helpers clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APOGEE_DESCENT_DETECTOR_CORE_DEFINES_SVH
`define APOGEE_DESCENT_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define APDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define APDD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APDD_ASSERT_IMP(lbl, ante, cons, msg)
`define APDD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/apdd_pkg.sv
// ----------------------------------------------------------------------------
// Apogee descent detector package
// Shared widths, register codes, reset values and types.
// ----------------------------------------------------------------------------
package apdd_pkg;

    localparam int WINDOW_LEN_DEF = 5;
    localparam int WARMUP_LEN_DEF = 10;

    localparam int ALT_W      = 25;
    localparam int RATE_W     = 21;
    localparam int ABS_W      = 20;
    localparam int CNT_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = 17;
    localparam int MINH_W     = 20;
    localparam int LIMIT_W    = 18;
    localparam int DROP_W     = 17;
    localparam int PDROP_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    localparam int OP_A_W  = 25;
    localparam int OP_B_W  = 17;
    localparam int PROD_W  = OP_A_W + OP_B_W;
    localparam int ACC_W   = 44;
    localparam int RATE_FRAC = 8;
    localparam int RATE_MAX  = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_MINH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_DROP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DROP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT    = 3'd7;

    localparam logic [GAIN_W-1:0]         RST_RATE_GAIN    = 16'd512;
    localparam logic [BASE_W-1:0]         RST_BASE_THRESH  = 17'd20;
    localparam logic [MINH_W-1:0]         RST_APOGEE_MINH  = 20'd1000;
    localparam logic signed [LIMIT_W-1:0] RST_APOGEE_RATE  = -18'sd50;
    localparam logic [DROP_W-1:0]         RST_APOGEE_DROP  = 17'd50;
    localparam logic signed [LIMIT_W-1:0] RST_DESCENT_RATE = -18'sd100;
    localparam logic [PDROP_W-1:0]        RST_PEAK_DROP    = 20'd500;
    localparam logic [CNT_W-1:0]          RST_REQ_COUNT    = 8'd5;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RATE  = 8'b0000_0010,
        S_RWAIT = 8'b0000_0100,
        S_RSAT  = 8'b0000_1000,
        S_MEAN  = 8'b0001_0000,
        S_MWAIT = 8'b0010_0000,
        S_DEC   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic issue;
        logic clear;
    } t_mac_ctl;

endpackage

### rtl/core/apogee_descent_detector_core.sv
// ----------------------------------------------------------------------------
// Apogee descent detector core
// Tracks peak altitude, derives a vertical rate and flags apogee and descent.
// ----------------------------------------------------------------------------
// Altitude samples enter on the slave stream, one item per check interval.
// Each item yields exactly one result item on the master stream carrying the
// apogee flag, the descent confirmation, the peak, the rate and the counter.
// The block accepts an item only while its sequencer is idle. During warm-up
// the sequencer goes from idle straight to the done state. After warm-up it
// steps through the rate, rate-wait, saturation, mean, mean-wait, decision
// and done states on the single shared multiply-accumulate unit: two terms
// for the rate and 3 + WINDOW_LEN terms for the mean comparison, each product
// registered before it is accumulated. The next item is accepted only after
// the last result has moved into the output register.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and processed, and its finish waits for the slot.
// Synchronous active-low reset clears the peak, warm-up count, apogee flag,
// counter and handshakes, and loads the register defaults. Configuration is
// written through i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle.
// ----------------------------------------------------------------------------
`include "apogee_descent_detector_core_defines.svh"

module apogee_descent_detector_core #(
    parameter int WINDOW_LEN = apdd_pkg::WINDOW_LEN_DEF,
    parameter int WARMUP_LEN = apdd_pkg::WARMUP_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [apdd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [apdd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [24:0] altitude_sample, [31:25] zero
    input  logic [apdd_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [0] apogee_seen, [1] descent_confirmed, [26:2] peak_altitude,
    // [47:27] vertical_rate, [55:48] descent_count
    output logic [apdd_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);
    import apdd_pkg::*;

    localparam int WARM_W    = $clog2(WARMUP_LEN + 1);
    localparam int WIN_IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TERM_ALT  = 0;
    localparam int TERM_BASE = 1;
    localparam int TERM_ABS  = 2;
    localparam int TERM_WIN0 = 3;
    localparam int TERM_LAST = TERM_WIN0 + WINDOW_LEN - 1;
    localparam int IDX_W     = $clog2(TERM_LAST + 1);

    localparam logic [WARM_W-1:0]        WARM_FULL   = WARM_W'(WARMUP_LEN);
    localparam logic signed [OP_B_W-1:0] K_TEN_WIN   = OP_B_W'(10 * WINDOW_LEN);
    localparam logic signed [OP_B_W-1:0] K_WIN       = OP_B_W'(WINDOW_LEN);
    localparam logic signed [OP_B_W-1:0] K_NEG_TEN   = -OP_B_W'(10);
    localparam logic signed [ACC_W-1:0]  RATE_HI     = ACC_W'(RATE_MAX);
    localparam logic signed [ACC_W-1:0]  RATE_LO     = -ACC_W'(RATE_MAX);
    localparam logic [CNT_W-1:0]         CNT_MAX     = '1;

    logic [GAIN_W-1:0]         r_gain;
    logic [BASE_W-1:0]         r_base;
    logic [MINH_W-1:0]         r_minh;
    logic signed [LIMIT_W-1:0] r_arl;
    logic [DROP_W-1:0]         r_adrop;
    logic signed [LIMIT_W-1:0] r_drl;
    logic [PDROP_W-1:0]        r_pdrop;
    logic [CNT_W-1:0]          r_req;

    t_state                    r_state;
    logic [IDX_W-1:0]          r_idx;
    logic signed [ALT_W-1:0]   r_win [WINDOW_LEN];
    logic signed [ALT_W-1:0]   r_alt;
    logic signed [ALT_W-1:0]   r_peak;
    logic [WARM_W-1:0]         r_warm;
    logic                      r_apogee;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_conf;
    logic signed [RATE_W-1:0]  r_rate;
    logic [ABS_W-1:0]          r_abs;

    logic                      r_out_valid;
    logic                      r_out_apogee;
    logic                      r_out_conf;
    logic signed [ALT_W-1:0]   r_out_peak;
    logic signed [RATE_W-1:0]  r_out_rate;
    logic [CNT_W-1:0]          r_out_cnt;

    logic                      accept;
    logic                      out_free;
    logic signed [ALT_W-1:0]   in_alt;
    logic [WARM_W-1:0]         warm_nx;
    t_mac_ctl                  mac_ctl;
    logic signed [OP_A_W-1:0]  op_a;
    logic signed [OP_B_W-1:0]  op_b;
    logic signed [ACC_W-1:0]   acc;
    logic [IDX_W-1:0]          term_off;
    logic [WIN_IDX_W-1:0]      win_sel;
    logic signed [ACC_W-1:0]   rate_full;
    logic signed [RATE_W-1:0]  rate_sat;
    logic signed [ALT_W+2:0]   peak_x;
    logic signed [ALT_W+2:0]   alt_x;
    logic                      apo_hit;
    logic                      desc;
    logic [CNT_W-1:0]          cnt_inc;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign in_alt   = i_s_tdata[ALT_W-1:0];
    assign warm_nx  = (r_warm < WARM_FULL) ? r_warm + 1'b1 : r_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= RST_RATE_GAIN;
            r_base  <= RST_BASE_THRESH;
            r_minh  <= RST_APOGEE_MINH;
            r_arl   <= RST_APOGEE_RATE;
            r_adrop <= RST_APOGEE_DROP;
            r_drl   <= RST_DESCENT_RATE;
            r_pdrop <= RST_PEAK_DROP;
            r_req   <= RST_REQ_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATE_GAIN:    r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_BASE_THRESH:  r_base  <= i_cfg_data[BASE_W-1:0];
                CFG_APOGEE_MINH:  r_minh  <= i_cfg_data[MINH_W-1:0];
                CFG_APOGEE_RATE:  r_arl   <= i_cfg_data[LIMIT_W-1:0];
                CFG_APOGEE_DROP:  r_adrop <= i_cfg_data[DROP_W-1:0];
                CFG_DESCENT_RATE: r_drl   <= i_cfg_data[LIMIT_W-1:0];
                CFG_PEAK_DROP:    r_pdrop <= i_cfg_data[PDROP_W-1:0];
                CFG_REQ_COUNT:    r_req   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign term_off = r_idx - IDX_W'(TERM_WIN0);
    assign win_sel  = term_off[WIN_IDX_W-1:0];

    always_comb begin
        mac_ctl.issue = (r_state == S_RATE) || (r_state == S_MEAN);
        mac_ctl.clear = accept || (r_state == S_RSAT);
        op_a = r_win[0];
        op_b = OP_B_W'($signed({1'b0, r_gain}));
        if (r_state == S_RATE) begin
            if (r_idx != '0) begin
                op_a = r_win[WINDOW_LEN-1];
                op_b = -OP_B_W'($signed({1'b0, r_gain}));
            end
        end else begin
            case (r_idx)
                IDX_W'(TERM_ALT): begin
                    op_a = r_alt;
                    op_b = K_TEN_WIN;
                end
                IDX_W'(TERM_BASE): begin
                    op_a = OP_A_W'($signed({1'b0, r_base}));
                    op_b = K_TEN_WIN;
                end
                IDX_W'(TERM_ABS): begin
                    op_a = OP_A_W'($signed({1'b0, r_abs}));
                    op_b = K_WIN;
                end
                default: begin
                    op_a = r_win[win_sel];
                    op_b = K_NEG_TEN;
                end
            endcase
        end
    end

    apdd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_acc   (acc)
    );

    always_comb begin
        rate_full = acc >>> RATE_FRAC;
        if (rate_full > RATE_HI) begin
            rate_sat = RATE_W'(RATE_HI);
        end else if (rate_full < RATE_LO) begin
            rate_sat = RATE_W'(RATE_LO);
        end else begin
            rate_sat = rate_full[RATE_W-1:0];
        end
    end

    always_comb begin
        peak_x  = (ALT_W+3)'(r_peak);
        alt_x   = (ALT_W+3)'(r_alt);
        apo_hit = (peak_x > (ALT_W+3)'($signed({1'b0, r_minh})))
               && (r_rate < RATE_W'(r_arl))
               && (alt_x < peak_x - (ALT_W+3)'($signed({1'b0, r_adrop})));
        desc    = acc[ACC_W-1]
               || (r_rate < RATE_W'(r_drl))
               || (alt_x < peak_x - (ALT_W+3)'($signed({1'b0, r_pdrop})));
        cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_alt <= in_alt;
            r_win[0] <= in_alt;
            for (int k = 1; k < WINDOW_LEN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
        if (r_state == S_RSAT) begin
            r_abs <= rate_sat[RATE_W-1] ? ABS_W'(-rate_sat) : ABS_W'(rate_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_peak   <= '0;
            r_warm   <= '0;
            r_apogee <= 1'b0;
            r_cnt    <= '0;
            r_conf   <= 1'b0;
            r_rate   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (in_alt > r_peak) begin
                            r_peak <= in_alt;
                        end
                        r_warm <= warm_nx;
                        r_conf <= 1'b0;
                        r_rate <= '0;
                        r_idx  <= '0;
                        r_state <= (warm_nx == WARM_FULL) ? S_RATE : S_DONE;
                    end
                end
                S_RATE: begin
                    if (r_idx != '0) begin
                        r_idx   <= '0;
                        r_state <= S_RWAIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_RWAIT: begin
                    r_state <= S_RSAT;
                end
                S_RSAT: begin
                    r_rate  <= rate_sat;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (r_idx == IDX_W'(TERM_LAST)) begin
                        r_idx   <= '0;
                        r_state <= S_MWAIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MWAIT: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (!r_apogee && apo_hit) begin
                        r_apogee <= 1'b1;
                    end else if (r_apogee) begin
                        if (desc) begin
                            r_cnt  <= cnt_inc;
                            r_conf <= (cnt_inc >= r_req);
                        end else if (r_cnt != '0) begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_apogee <= r_apogee;
            r_out_conf   <= r_conf;
            r_out_peak   <= r_peak;
            r_out_rate   <= r_rate;
            r_out_cnt    <= r_cnt;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cnt, r_out_rate, r_out_peak, r_out_conf, r_out_apogee};

    `APDD_ASSERT_IMP(a_cnt_before_apogee, !r_apogee, r_cnt == '0,
        "Descent counter moved before apogee was flagged")
    `APDD_ASSERT_IMP(a_conf_needs_apogee, r_out_valid && r_out_conf, r_out_apogee,
        "Descent confirmed without apogee")
    `APDD_ASSERT_IMP(a_rate_zero_warmup, (r_state == S_DONE) && (r_warm != WARM_FULL),
        r_rate == '0, "Nonzero rate during warm-up")
    `APDD_ASSERT_NXT(a_accept_next, accept, (r_state == S_RATE) || (r_state == S_DONE),
        "Sequencer did not start after an accepted item")

endmodule

### rtl/core/apdd_mac.sv
// ----------------------------------------------------------------------------
// Apogee descent detector multiply-accumulate unit
// Registered signed product followed by a registered accumulator.
// ----------------------------------------------------------------------------
module apdd_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  apdd_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [apdd_pkg::OP_A_W-1:0]    i_a,
    input  logic signed [apdd_pkg::OP_B_W-1:0]    i_b,
    output logic signed [apdd_pkg::ACC_W-1:0]     o_acc
);
    import apdd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.issue;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

### verif/apogee_descent_detector_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Apogee descent detector core testbench
// Streams altitude items into the core and checks every result item against
// a cycle-free model of the detector kept in this file. A short table covers
// warm-up, the sample extremes, rate saturation, the apogee step and the
// first confirmations; random flight profiles under many register settings
// follow, with random idling on both streams.
// ----------------------------------------------------------------------------
module apogee_descent_detector_core_test;
    import apdd_pkg::*;

    typedef struct packed {
        logic                     apogee_seen;
        logic                     descent_confirmed;
        logic signed [ALT_W-1:0]  peak;
        logic signed [RATE_W-1:0] vrate;
        logic [CNT_W-1:0]         count;
    } flight_result_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic                    fixed_exp;
        flight_result_t          res;
    } flight_row_t;

    localparam int SAMPLE_ROWS = 20;
    localparam int ALT_TOP     = 16777215;

    // Rows 1 to 5 fall in warm-up, so their results follow from the peak alone.
    localparam flight_row_t SAMPLE_TABLE [SAMPLE_ROWS] = '{
        '{25'sd0,          1'b1, '{1'b0, 1'b0, 25'sd0,        21'sd0, 8'd0}},
        '{25'sd10000000,   1'b1, '{1'b0, 1'b0, 25'sd10000000, 21'sd0, 8'd0}},
        '{-25'sd100000,    1'b1, '{1'b0, 1'b0, 25'sd10000000, 21'sd0, 8'd0}},
        '{25'sh0FFFFFF,    1'b1, '{1'b0, 1'b0, 25'sh0FFFFFF,  21'sd0, 8'd0}},
        '{25'sh1000000,    1'b1, '{1'b0, 1'b0, 25'sh0FFFFFF,  21'sd0, 8'd0}},
        '{25'sd1000000,    1'b0, '0},
        '{25'sd990000,     1'b0, '0},
        '{25'sd980000,     1'b0, '0},
        '{25'sd970000,     1'b0, '0},
        '{25'sd16000000,   1'b0, '0},
        '{25'sd15000000,   1'b0, '0},
        '{25'sd100000,     1'b0, '0},
        '{25'sd90000,      1'b0, '0},
        '{25'sd80000,      1'b0, '0},
        '{25'sd70000,      1'b0, '0},
        '{25'sd60000,      1'b0, '0},
        '{25'sd50000,      1'b0, '0},
        '{25'sd50000,      1'b0, '0},
        '{25'sd40000,      1'b0, '0},
        '{25'sd45000,      1'b0, '0}
    };

    localparam longint REG_LO [8] = '{0, 0, 0, -100000, 0, -100000, 0, 1};
    localparam longint REG_HI [8] = '{65535, 100000, 1000000, 0, 100000, 0, 1000000, 255};

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    apogee_descent_detector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Detector model state and its copy of the registers.
    logic signed [ALT_W-1:0]   alt_hist [WINDOW_LEN_DEF];
    int                        warm_cnt       = 0;
    logic signed [ALT_W-1:0]   peak_alt       = '0;
    logic                      apogee_latched = 1'b0;
    logic [CNT_W-1:0]          leaky_cnt      = '0;
    logic [GAIN_W-1:0]         cfg_gain       = RST_RATE_GAIN;
    logic [BASE_W-1:0]         cfg_base       = RST_BASE_THRESH;
    logic [MINH_W-1:0]         cfg_min_height = RST_APOGEE_MINH;
    logic signed [LIMIT_W-1:0] cfg_apogee_rate = RST_APOGEE_RATE;
    logic [DROP_W-1:0]         cfg_apogee_drop = RST_APOGEE_DROP;
    logic signed [LIMIT_W-1:0] cfg_descent_rate = RST_DESCENT_RATE;
    logic [PDROP_W-1:0]        cfg_peak_drop  = RST_PEAK_DROP;
    logic [CNT_W-1:0]          cfg_req_count  = RST_REQ_COUNT;

    flight_result_t pending_flight_results [$];
    int             pending_item_ids [$];
    flight_result_t want_res;
    int             want_id;

    logic no_idling       = 1'b0;
    int   mismatch_count  = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   settings_count  = 0;
    int   confirm_total   = 0;
    int   counter_top     = 0;

    task automatic advance_flight(input logic signed [ALT_W-1:0] alt,
                                  output flight_result_t res);
        longint alt_l;
        longint sum;
        longint prod;
        longint vrate;
        longint abs_rate;
        longint lhs;
        longint rhs;
        logic   desc;
        logic   confirmed;
        begin
            alt_l     = alt;
            vrate     = 0;
            confirmed = 1'b0;
            if (alt_l > longint'(peak_alt))
                peak_alt = alt;
            for (int i = WINDOW_LEN_DEF - 1; i > 0; i--)
                alt_hist[i] = alt_hist[i-1];
            alt_hist[0] = alt;
            if (warm_cnt < WARMUP_LEN_DEF)
                warm_cnt++;
            if (warm_cnt == WARMUP_LEN_DEF) begin
                sum = 0;
                for (int i = 0; i < WINDOW_LEN_DEF; i++)
                    sum += longint'(alt_hist[i]);
                prod = (longint'(alt_hist[0]) - longint'(alt_hist[WINDOW_LEN_DEF-1]))
                       * longint'(cfg_gain);
                vrate = prod >>> RATE_FRAC;
                if (vrate > RATE_MAX)
                    vrate = RATE_MAX;
                if (vrate < -RATE_MAX)
                    vrate = -RATE_MAX;
                abs_rate = (vrate < 0) ? -vrate : vrate;
                if (!apogee_latched && longint'(peak_alt) > longint'(cfg_min_height)
                        && vrate < longint'(cfg_apogee_rate)
                        && alt_l < longint'(peak_alt) - longint'(cfg_apogee_drop)) begin
                    apogee_latched = 1'b1;
                end else if (apogee_latched) begin
                    // The margin below the window mean is compared without rounding.
                    lhs  = 10 * WINDOW_LEN_DEF * alt_l;
                    rhs  = 10 * sum - 10 * WINDOW_LEN_DEF * longint'(cfg_base)
                           - WINDOW_LEN_DEF * abs_rate;
                    desc = (lhs < rhs) || (vrate < longint'(cfg_descent_rate))
                           || (alt_l < longint'(peak_alt) - longint'(cfg_peak_drop));
                    if (desc) begin
                        if (leaky_cnt != 8'd255)
                            leaky_cnt++;
                        confirmed = (leaky_cnt >= cfg_req_count);
                    end else if (leaky_cnt != 8'd0) begin
                        leaky_cnt--;
                    end
                end
            end
            if (confirmed)
                confirm_total++;
            if (int'(leaky_cnt) > counter_top)
                counter_top = leaky_cnt;
            res.apogee_seen       = apogee_latched;
            res.descent_confirmed = confirmed;
            res.peak              = peak_alt;
            res.vrate             = vrate[RATE_W-1:0];
            res.count             = leaky_cnt;
        end
    endtask

    task automatic report_mismatch(input string what, input int item,
                                   input longint got, input longint want);
        $display("MISMATCH %s (item %0d): got %0d, expected %0d", what, item, got, want);
        mismatch_count++;
    endtask

    task automatic send_sample(input logic signed [ALT_W-1:0] alt, input logic fixed_exp,
                               input flight_result_t typed_res);
        int             gap;
        flight_result_t pred;
        begin
            gap = no_idling ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {{(IN_TDATA_W-ALT_W){1'b0}}, alt};
            do @(posedge i_clk); while (!o_s_tready);
            advance_flight(alt, pred);
            pending_flight_results.push_back(fixed_exp ? typed_res : pred);
            pending_item_ids.push_back(items_sent);
            items_sent++;
        end
    endtask

    task automatic drain_results;
        i_s_tvalid <= 1'b0;
        while (pending_flight_results.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic program_registers(input longint vals [8]);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_IDX_W-1:0]  idx;
        begin
            for (int r = 0; r < 8; r++) begin
                data = vals[r][CFG_DATA_W-1:0];
                idx  = r[CFG_IDX_W-1:0];
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idx;
                i_cfg_data <= data;
                @(posedge i_clk);
                case (idx)
                    CFG_RATE_GAIN:    cfg_gain         = data[GAIN_W-1:0];
                    CFG_BASE_THRESH:  cfg_base         = data[BASE_W-1:0];
                    CFG_APOGEE_MINH:  cfg_min_height   = data[MINH_W-1:0];
                    CFG_APOGEE_RATE:  cfg_apogee_rate  = data[LIMIT_W-1:0];
                    CFG_APOGEE_DROP:  cfg_apogee_drop  = data[DROP_W-1:0];
                    CFG_DESCENT_RATE: cfg_descent_rate = data[LIMIT_W-1:0];
                    CFG_PEAK_DROP:    cfg_peak_drop    = data[PDROP_W-1:0];
                    CFG_REQ_COUNT:    cfg_req_count    = data[CNT_W-1:0];
                    default: ;
                endcase
            end
            i_cfg_we <= 1'b0;
            settings_count++;
        end
    endtask

    initial begin
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!no_idling && $urandom_range(0, 4) != 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_flight_results.size() == 0) begin
                report_mismatch("result with no item pending", -1, o_m_tdata[26:2], 0);
            end else begin
                want_res = pending_flight_results.pop_front();
                want_id  = pending_item_ids.pop_front();
                results_checked++;
                if (o_m_tdata[0] !== want_res.apogee_seen)
                    report_mismatch("apogee_seen", want_id, o_m_tdata[0],
                                    want_res.apogee_seen);
                if (o_m_tdata[1] !== want_res.descent_confirmed)
                    report_mismatch("descent_confirmed", want_id, o_m_tdata[1],
                                    want_res.descent_confirmed);
                if (o_m_tdata[26:2] !== want_res.peak)
                    report_mismatch("peak_altitude", want_id,
                                    longint'($signed(o_m_tdata[26:2])),
                                    longint'(want_res.peak));
                if (o_m_tdata[47:27] !== want_res.vrate)
                    report_mismatch("vertical_rate", want_id,
                                    longint'($signed(o_m_tdata[47:27])),
                                    longint'(want_res.vrate));
                if (o_m_tdata[55:48] !== want_res.count)
                    report_mismatch("descent_count", want_id, o_m_tdata[55:48],
                                    want_res.count);
            end
        end
    end

    initial begin
        longint      vals [8];
        longint      walk;
        longint      slope;
        longint      pick_val;
        int          pick;
        logic [31:0] raw;
        logic signed [ALT_W-1:0] alt;
        begin
            repeat (11) @(posedge i_clk);
            i_rst_n <= 1'b1;
            @(posedge i_clk);

            for (int n = 0; n < SAMPLE_ROWS; n++)
                send_sample(SAMPLE_TABLE[n].alt, SAMPLE_TABLE[n].fixed_exp,
                            SAMPLE_TABLE[n].res);
            drain_results();

            for (int ph = 0; ph < 10; ph++) begin
                case (ph)
                    0: vals = '{65535, 100000, 1000000, 0, 100000, 0, 1000000, 255};
                    1: vals = '{0, 0, 0, -100000, 0, -100000, 0, 0};
                    2: vals = '{RST_RATE_GAIN, RST_BASE_THRESH, RST_APOGEE_MINH,
                                RST_APOGEE_RATE, RST_APOGEE_DROP, RST_DESCENT_RATE,
                                RST_PEAK_DROP, RST_REQ_COUNT};
                    default: begin
                        for (int r = 0; r < 8; r++) begin
                            pick = $urandom_range(0, 7);
                            case (pick)
                                0: pick_val = REG_LO[r];
                                1: pick_val = REG_HI[r];
                                2: pick_val = longint'($urandom());
                                default: pick_val = REG_LO[r] + longint'($urandom_range(
                                             0, int'(REG_HI[r] - REG_LO[r])));
                            endcase
                            vals[r] = pick_val;
                        end
                    end
                endcase
                program_registers(vals);
                no_idling = (ph == 3 || ph == 7);

                if (ph == 0) begin
                    // A long steady fall drives the counter into saturation.
                    walk = 16700000;
                    for (int k = 0; k < 300; k++) begin
                        walk = walk - 4000 + longint'($urandom_range(0, 400)) - 200;
                        alt  = walk[ALT_W-1:0];
                        send_sample(alt, 1'b0, '0);
                    end
                end else begin
                    walk  = ALT_TOP - longint'($urandom_range(0, 1500000));
                    slope = longint'($urandom_range(0, 4000)) - 2000;
                    for (int k = 0; k < 60; k++) begin
                        if ($urandom_range(0, 15) == 0)
                            slope = longint'($urandom_range(0, 4000)) - 2000;
                        pick = $urandom_range(0, 19);
                        raw  = $urandom();
                        if (pick < 2) begin
                            alt = raw[ALT_W-1:0];
                        end else if (pick == 2) begin
                            alt = ALT_W'(-100000 + longint'($urandom_range(0, 10100000)));
                        end else begin
                            walk = walk + slope + longint'($urandom_range(0, 3000)) - 1500;
                            if (walk > ALT_TOP) begin
                                walk  = ALT_TOP;
                                slope = -longint'($urandom_range(0, 2000));
                            end
                            alt = walk[ALT_W-1:0];
                        end
                        send_sample(alt, 1'b0, '0);
                    end
                end
                drain_results();
            end

            no_idling = 1'b0;
            repeat (40) @(posedge i_clk);
            $display("Summary: %0d altitude items, %0d results checked, %0d register settings",
                     items_sent, results_checked, settings_count);
            $display("Summary: apogee flagged %0d, %0d confirmations, counter peaked at %0d",
                     apogee_latched, confirm_total, counter_top);
            if (mismatch_count == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
            $finish;
        end
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still pending", pending_flight_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
